// File: design/pcbr_pkg.sv
// ----------------------------------------------------------------------------
// pcbr_pkg
// Types and constants shared by the bandwidth regulator and its channels.
// ----------------------------------------------------------------------------
package pcbr_pkg;

   localparam int PeriodW   = 20;
   localparam int CountW    = 28;
   localparam int EventW    = 8;
   localparam int CoreIdxW  = 2;
   localparam int MaskW     = 4;
   localparam int PeriodsW  = 32;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 28;

   localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(1000);
   localparam logic [CountW-1:0]  BudgetReset = CountW'(32768);
   localparam logic [CountW-1:0]  UsageMax    = 28'hfffffff;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_EVENT = 1'b1
   } opcode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PERIOD   = 3'd0,
      CSR_BUDGET0  = 3'd1,
      CSR_BUDGET1  = 3'd2,
      CSR_BUDGET2  = 3'd3,
      CSR_BUDGET3  = 3'd4,
      CSR_REALTIME = 3'd5
   } csr_index_type;

endpackage

// File: design/pcbr_req_if.sv
// ----------------------------------------------------------------------------
// pcbr_req_if
// Request channel: ticks and per-core miss event reports, valid/ready.
// ----------------------------------------------------------------------------
interface pcbr_req_if import pcbr_pkg::*; ();

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [CoreIdxW-1:0] core_index;
   logic [EventW-1:0]   event_count;

   modport source (output valid, output opcode, output core_index,
                   output event_count, input ready);
   modport sink   (input valid, input opcode, input core_index,
                   input event_count, output ready);

endinterface

// File: design/pcbr_rsp_if.sv
// ----------------------------------------------------------------------------
// pcbr_rsp_if
// Response channel: throttle state after each transaction, valid/ready.
// ----------------------------------------------------------------------------
interface pcbr_rsp_if import pcbr_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [MaskW-1:0]    core_throttle;
   logic                newly_throttled;
   logic                period_ended;
   logic [PeriodsW-1:0] period_count;

   modport source (output valid, output core_throttle, output newly_throttled,
                   output period_ended, output period_count, input ready);
   modport sink   (input valid, input core_throttle, input newly_throttled,
                   input period_ended, input period_count, output ready);

endinterface

// File: design/per_core_bandwidth_regulator_unit.sv
// ----------------------------------------------------------------------------
// per_core_bandwidth_regulator_unit
// Periodic per-core memory bandwidth regulator with saturating usage counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per tick or per miss-event report from
//   a core. rsp_chan returns exactly one transaction per request: the throttle
//   mask after it, whether it throttled its core, whether it closed a period,
//   and the wrapping count of closed periods.
//   csr_we/csr_index/csr_wdata write the period length, the per-core budgets
//   and the real-time mask; write them only while the block is idle. Zero
//   writes to the period or a budget are dropped.
// Timing:
//   A request lands in the input register, then one pass of logic (a 4:1
//   usage read, a 28-bit saturating add and a budget compare, or a 20-bit
//   tick increment and compare) updates state and the response register.
//   The response register is loaded from the input register and drives
//   rsp_chan. Throughput: one transaction per cycle unless rsp_chan stalls.
// Reset clears all usage, throttle and period state and loads the register
//   defaults. When rsp_chan stalls, the response holds, the input register
//   fills, and req_chan.ready drops until the response is taken.
// ----------------------------------------------------------------------------
module per_core_bandwidth_regulator_unit import pcbr_pkg::*; #(
   parameter int CORES = 4
) (
   input  logic                clock,
   input  logic                reset,
   pcbr_req_if.sink            req_chan,
   pcbr_rsp_if.source          rsp_chan,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int CoreW = (CORES > 1) ? $clog2(CORES) : 1;

   // configuration
   logic [PeriodW-1:0] period_ff;
   logic [CountW-1:0]  budget_ff [CORES];
   logic [CORES-1:0]   rt_ff;
   logic [CsrIdxW-1:0] budget_sel;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_op_ff;
   logic [CoreIdxW-1:0] s1_core_ff;
   logic [EventW-1:0]   s1_events_ff;

   // regulator state
   logic [CountW-1:0]   usage_ff [CORES];
   logic [CountW-1:0]   usage_in [CORES];
   logic [CORES-1:0]    thr_ff, thr_in;
   logic [PeriodW-1:0]  tick_ff, tick_in;
   logic [PeriodsW-1:0] periods_ff, periods_in;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic newly_ff, newly_in;
   logic ended_ff, ended_in;

   logic               req_fire;
   logic               advance;
   logic               load;
   logic               core_ok;
   logic [CoreW-1:0]   core_sel;
   logic [CountW:0]    sum_wide;
   logic [CountW-1:0]  sum_sat;
   logic [PeriodW-1:0] tick_next;
   logic               period_hit;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   assign budget_sel = csr_index - CsrIdxW'(CSR_BUDGET0);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PeriodReset;
         rt_ff     <= '0;
         for (int c = 0; c < CORES; c++) begin
            budget_ff[c] <= BudgetReset;
         end
      end else if (csr_we) begin
         case (csr_index) inside
            CSR_PERIOD: begin
               if (csr_wdata[PeriodW-1:0] != '0) begin
                  period_ff <= csr_wdata[PeriodW-1:0];
               end
            end
            CSR_BUDGET0, CSR_BUDGET1, CSR_BUDGET2, CSR_BUDGET3: begin
               for (int c = 0; c < CORES; c++) begin
                  if (budget_sel == CsrIdxW'(c) && csr_wdata != '0) begin
                     budget_ff[c] <= csr_wdata;
                  end
               end
            end
            CSR_REALTIME: begin
               rt_ff <= csr_wdata[CORES-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load           = s1_valid_ff && advance;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff     <= req_chan.opcode;
         s1_core_ff   <= req_chan.core_index;
         s1_events_ff <= req_chan.event_count;
      end
   end

   // ------------------------------------------------------------------
   // Regulation pass
   // ------------------------------------------------------------------
   assign core_ok    = int'(s1_core_ff) < CORES;
   assign core_sel   = s1_core_ff[CoreW-1:0];
   assign sum_wide   = {1'b0, usage_ff[core_sel]} + (CountW+1)'(s1_events_ff);
   assign sum_sat    = sum_wide[CountW] ? UsageMax : sum_wide[CountW-1:0];
   assign tick_next  = tick_ff + PeriodW'(1);
   assign period_hit = (tick_next >= period_ff) || (tick_next == '0);

   always_comb begin
      usage_in   = usage_ff;
      thr_in     = thr_ff;
      tick_in    = tick_ff;
      periods_in = periods_ff;
      newly_in   = newly_ff;
      ended_in   = ended_ff;
      if (load) begin
         newly_in = 1'b0;
         ended_in = 1'b0;
         if (s1_op_ff == OP_TICK) begin
            if (period_hit) begin
               // close the period: clear usage and throttles
               for (int c = 0; c < CORES; c++) begin
                  usage_in[c] = '0;
               end
               thr_in     = '0;
               tick_in    = '0;
               periods_in = periods_ff + PeriodsW'(1);
               ended_in   = 1'b1;
            end else begin
               tick_in = tick_next;
            end
         end else if (core_ok) begin
            usage_in[core_sel] = sum_sat;
            if (sum_sat >= budget_ff[core_sel] && !rt_ff[core_sel] &&
                !thr_ff[core_sel]) begin
               thr_in[core_sel] = 1'b1;
               newly_in         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CORES; c++) begin
            usage_ff[c] <= '0;
         end
         thr_ff     <= '0;
         tick_ff    <= '0;
         periods_ff <= '0;
         newly_ff   <= 1'b0;
         ended_ff   <= 1'b0;
      end else begin
         usage_ff   <= usage_in;
         thr_ff     <= thr_in;
         tick_ff    <= tick_in;
         periods_ff <= periods_in;
         newly_ff   <= newly_in;
         ended_ff   <= ended_in;
      end
   end

   // State only moves when a new response loads, so it doubles as the
   // held response payload.
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.core_throttle   = MaskW'(thr_ff);
   assign rsp_chan.newly_throttled = newly_ff;
   assign rsp_chan.period_ended    = ended_ff;
   assign rsp_chan.period_count    = periods_ff;

`ifndef ASSERT_OFF
   a_end_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(ended_ff && newly_ff))
      else $error("period end and new throttle in one response");

   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ended_ff) |-> (thr_ff == '0))
      else $error("throttles not cleared at period end");

   a_period_step : assert property (@(posedge clock) disable iff (reset)
      (load && s1_op_ff == OP_TICK && period_hit) |=>
         (periods_ff == $past(periods_ff) + PeriodsW'(1)))
      else $error("period count did not advance");

   a_rt_never : assert property (@(posedge clock) disable iff (reset)
      (load && newly_in) |-> !rt_ff[core_sel])
      else $error("real-time core throttled");
`endif

endmodule
